[rtl/lbp_pkg.sv]
package lbp_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned LABEL_W   = 6;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W     = 32;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam logic [CFG_W-1:0] MIN_DIM    = 11'd3;
  localparam logic [CFG_W-1:0] MAX_HEIGHT = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIFORM_MODE = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
  } lbp_geom_t;

  typedef struct packed {
    logic [PIX_W-1:0] code;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } lbp_item_t;

endpackage

[rtl/lbp_front.sv]
module lbp_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lbp_pkg::lbp_geom_t           geom_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lbp_pkg::PIX_W-1:0]    s_axis_tdata,
  input  logic [lbp_pkg::QCNT_W-1:0]   q_count_i,
  output logic                         push_o,
  output lbp_pkg::lbp_item_t           item_o
);
  import lbp_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [CW-1:0]    col_q, col_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] win_q [6];
  logic [PIX_W-1:0] top_rd_q, mid_rd_q;

  logic             s1_valid_q;
  logic             s1_res_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_addr_q;
  logic [POS_W-1:0] s1_ccol_q, s1_crow_q;
  logic             s1_fend_q;

  logic [CMPW-1:0]  w_lim, c_ext, c_inc, c_dec;
  logic [CFG_W-1:0] h_lim, r_ext, r_inc;
  logic             row_end, frame_last, has_res, s_fire;
  logic [QCNT_W:0]  inflight;
  logic [PIX_W-1:0] code;
  logic [PIX_W-1:0] ctr;

  always_comb begin
    if (geom_i.width < MIN_DIM) begin
      w_lim = CMPW'(MIN_DIM);
    end else if (CMPW'(geom_i.width) > CMPW'(MAX_WIDTH)) begin
      w_lim = CMPW'(MAX_WIDTH);
    end else begin
      w_lim = CMPW'(geom_i.width);
    end
    if (geom_i.height < MIN_DIM) begin
      h_lim = MIN_DIM;
    end else if (geom_i.height > MAX_HEIGHT) begin
      h_lim = MAX_HEIGHT;
    end else begin
      h_lim = geom_i.height;
    end
  end

  assign c_ext      = CMPW'(col_q);
  assign c_inc      = c_ext + 1'b1;
  assign c_dec      = c_ext - 1'b1;
  assign r_ext      = CFG_W'(row_q);
  assign r_inc      = r_ext + 1'b1;
  assign row_end    = c_inc >= w_lim;
  assign frame_last = r_inc >= h_lim;
  assign has_res    = (row_q >= POS_W'(2)) && (col_q >= CW'(2)) && (c_ext < w_lim)
                      && (r_ext < h_lim);

  assign inflight      = {1'b0, q_count_i} + (QCNT_W + 1)'(s1_valid_q);
  assign s_axis_tready = inflight < (QCNT_W + 1)'(QDEPTH);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_last ? '0 : r_inc[POS_W-1:0];
    end else begin
      col_d = c_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
    end else begin
      s1_valid_q <= s_fire;
      if (s_fire) begin
        col_q    <= col_d;
        row_q    <= row_d;
        s1_res_q <= has_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      top_rd_q  <= upper_mem[col_q];
      mid_rd_q  <= middle_mem[col_q];
      s1_pix_q  <= s_axis_tdata;
      s1_addr_q <= col_q;
      s1_ccol_q <= c_dec[POS_W-1:0];
      s1_crow_q <= row_q - 1'b1;
      s1_fend_q <= row_end && frame_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      upper_mem[s1_addr_q]  <= mid_rd_q;
      middle_mem[s1_addr_q] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (s1_valid_q) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_rd_q;
      win_q[4] <= mid_rd_q;
      win_q[5] <= s1_pix_q;
    end
  end

  assign ctr = win_q[4];
  always_comb begin
    code    = '0;
    code[7] = win_q[0] > ctr;
    code[6] = win_q[1] > ctr;
    code[5] = win_q[2] > ctr;
    code[4] = win_q[5] > ctr;
    code[3] = s1_pix_q > ctr;
    code[2] = mid_rd_q > ctr;
    code[1] = top_rd_q > ctr;
    code[0] = win_q[3] > ctr;
  end

  assign push_o         = s1_valid_q && s1_res_q;
  assign item_o.code      = code;
  assign item_o.col       = s1_ccol_q;
  assign item_o.row       = s1_crow_q;
  assign item_o.frame_end = s1_fend_q;

endmodule

[rtl/lbp_queue.sv]
module lbp_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  lbp_pkg::lbp_item_t           item_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output lbp_pkg::lbp_item_t           item_o,
  output logic [lbp_pkg::QCNT_W-1:0]   count_o
);
  import lbp_pkg::*;

  lbp_item_t         fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = fifo_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) fifo_q[wptr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (do_pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
    end
  end

endmodule

[rtl/lbp_back.sv]
module lbp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          uniform_mode_i,
  input  logic                          q_valid_i,
  input  lbp_pkg::lbp_item_t            item_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lbp_pkg::LABEL_W-1:0]   label_o,
  output logic [lbp_pkg::POS_W-1:0]     col_o,
  output logic [lbp_pkg::POS_W-1:0]     row_o,
  output logic                          m_axis_tlast
);
  import lbp_pkg::*;

  localparam logic [LABEL_W-1:0] DEF_UNIFORM = 6'd9;
  localparam logic [LABEL_W-1:0] DEF_OTHER   = 6'd36;

  function automatic logic [PIX_W-1:0] strip_tz(input logic [PIX_W-1:0] c);
    logic [PIX_W-1:0] v;
    v = c;
    if (v != '0) begin
      for (int i = 0; i < PIX_W; i++) begin
        if (!v[0]) v = v >> 1;
      end
    end
    return v;
  endfunction

  function automatic logic [LABEL_W:0] label_rom(input logic [PIX_W-1:0] c);
    logic [LABEL_W:0] e;
    e = '0;
    case (c)
      8'hff:   e = {1'b1, 6'd0};
      8'h7f:   e = {1'b1, 6'd1};
      8'h3f:   e = {1'b1, 6'd2};
      8'h1f:   e = {1'b1, 6'd3};
      8'h0f:   e = {1'b1, 6'd4};
      8'h07:   e = {1'b1, 6'd5};
      8'h03:   e = {1'b1, 6'd6};
      8'h01:   e = {1'b1, 6'd7};
      8'h00:   e = {1'b1, 6'd8};
      8'h5f:   e = {1'b1, 6'd9};
      8'h6f:   e = {1'b1, 6'd10};
      8'h77:   e = {1'b1, 6'd11};
      8'h2f:   e = {1'b1, 6'd12};
      8'h4f:   e = {1'b1, 6'd13};
      8'h37:   e = {1'b1, 6'd14};
      8'h57:   e = {1'b1, 6'd15};
      8'h67:   e = {1'b1, 6'd16};
      8'h5b:   e = {1'b1, 6'd17};
      8'h17:   e = {1'b1, 6'd18};
      8'h27:   e = {1'b1, 6'd19};
      8'h47:   e = {1'b1, 6'd20};
      8'h1b:   e = {1'b1, 6'd21};
      8'h2b:   e = {1'b1, 6'd22};
      8'h4b:   e = {1'b1, 6'd23};
      8'h33:   e = {1'b1, 6'd24};
      8'h53:   e = {1'b1, 6'd25};
      8'h55:   e = {1'b1, 6'd26};
      8'h0b:   e = {1'b1, 6'd27};
      8'h13:   e = {1'b1, 6'd28};
      8'h23:   e = {1'b1, 6'd29};
      8'h43:   e = {1'b1, 6'd30};
      8'h15:   e = {1'b1, 6'd31};
      8'h25:   e = {1'b1, 6'd32};
      8'h05:   e = {1'b1, 6'd33};
      8'h09:   e = {1'b1, 6'd34};
      8'h11:   e = {1'b1, 6'd35};
      default: e = '0;
    endcase
    return e;
  endfunction

  logic             valid_q;
  logic [LABEL_W:0] rom_e;
  logic [LABEL_W-1:0] label_d;

  assign pop_o = q_valid_i && (!valid_q || m_axis_tready);
  assign rom_e = label_rom(strip_tz(item_i.code));
  assign label_d = rom_e[LABEL_W] ? rom_e[LABEL_W-1:0]
                 : (uniform_mode_i ? DEF_UNIFORM : DEF_OTHER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      label_o      <= label_d;
      col_o        <= item_i.col;
      row_o        <= item_i.row;
      m_axis_tlast <= item_i.frame_end;
    end
  end

  assign m_axis_tvalid = valid_q;

endmodule

[rtl/lbp_texture_label_stream.sv]
// Streaming 3x3 local binary pattern labeller. Takes one 8-bit grey pixel per item in
// raster order and gives one label item for each interior centre pixel, none for border
// pixels; tlast marks the last label of a frame. Throughput is one pixel per cycle
// unless input is held off: each line store is read and written once per pixel through
// its own ports. A label passes the line store read register, the compare into the queue
// and the label lookup into the output register, and leaves when the output side is ready.
// A four-entry queue sits between the window logic and the label lookup; input is held
// off whenever the items in that queue plus a pixel in the window stage reach four. The
// user writes geometry and mode registers only while idle; the block does not enforce it.
module lbp_texture_label_stream #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lbp_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [lbp_pkg::OUT_W-1:0]         m_axis_tdata,  // [5:0] label, [15:6] center_column,
                                                           // [25:16] center_row, [31:26] zero
  output logic                              m_axis_tlast   // frame_end
);
  import lbp_pkg::*;

  logic               uniform_q;
  lbp_geom_t          geom_q;
  logic               push;
  lbp_item_t          front_item, queue_item;
  logic               pop, q_valid;
  logic [QCNT_W-1:0]  q_count;
  logic [LABEL_W-1:0] label;
  logic [POS_W-1:0]   ccol, crow;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uniform_q     <= 1'b0;
      geom_q.width  <= 11'd640;
      geom_q.height <= 11'd480;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UNIFORM_MODE: uniform_q     <= cfg_data_i[0];
        REG_IMAGE_WIDTH:  geom_q.width  <= cfg_data_i;
        REG_IMAGE_HEIGHT: geom_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lbp_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom_q),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_count_i    (q_count),
    .push_o       (push),
    .item_o       (front_item)
  );

  lbp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .valid_o(q_valid),
    .item_o (queue_item),
    .count_o(q_count)
  );

  lbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .uniform_mode_i(uniform_q),
    .q_valid_i     (q_valid),
    .item_i        (queue_item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .label_o       (label),
    .col_o         (ccol),
    .row_o         (crow),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, crow, ccol, label};

endmodule
